/* rtl/core/sbso_pkg.sv */
package sbso_pkg;

	localparam int VOLUME_DEPTH = 18;
	localparam int WORD_W = 32;
	localparam int NORM_W = 32;
	localparam int SLABS = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam int IDX_ORIGIN = 0;
	localparam int IDX_MIN = 3;
	localparam int IDX_MAX = 6;
	localparam int IDX_RECIP = 9;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TEST = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CAUSE_HIT = 2'd0,
		CAUSE_BOUNDS = 2'd1,
		CAUSE_PARALLEL = 2'd2,
		CAUSE_EMPTY = 2'd3
	} cause_t;

	typedef enum logic [1:0] {
		NRM_IDLE,
		NRM_SQUARE,
		NRM_ROOT
	} nrm_state_t;

	typedef logic signed [WORD_W-1:0] vol_t [VOLUME_DEPTH];
	typedef logic [NORM_W-1:0] norm_t [SLABS];

	typedef struct packed {
		logic busy;
		logic done;
	} nrm_stat_t;

	typedef struct packed {
		logic bounds;
		logic [SLABS-1:0] par;
		logic [SLABS-1:0] par_rej;
	} slab_flags_t;

endpackage

/* rtl/core/segment_box_slab_overlap.sv */
// channel | valid       | stall        | payload
// item    | item_valid  | item_stall   | action word_index word_value feet_x/y/z
//         |             |              | body_radius body_height
// result  | result_valid| result_stall | overlap reject_cause
//
// Test items enter one per cycle unless item_stall holds them; a bit-per-stage divider
// follows three stages of bounds, products and slab sums.
// Load items wait until every queued or in-flight test has left the pipeline.
// A load to a reciprocal word starts a horizontal-norm square root for
// that slab; tests wait until it ends. Reset clears the volume words and norms.
// result_stall freezes the whole back pipeline; the four-entry queue absorbs input.
module segment_box_slab_overlap #(
	parameter int COORD_WIDTH = 24,
	parameter int RECIP_FRAC_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic action,
	input  logic [4:0] word_index,
	input  logic signed [31:0] word_value,
	input  logic signed [COORD_WIDTH-1:0] feet_x,
	input  logic signed [COORD_WIDTH-1:0] feet_y,
	input  logic signed [COORD_WIDTH-1:0] feet_z,
	input  logic [COORD_WIDTH-2:0] body_radius,
	input  logic [COORD_WIDTH-2:0] body_height,
	output logic result_valid,
	input  logic result_stall,
	output logic overlap,
	output logic [1:0] reject_cause
);
	import sbso_pkg::*;

	vol_t vol;
	norm_t norm;
	logic push, pop, q_full, q_nonempty, back_busy;
	logic signed [COORD_WIDTH-1:0] q_x, q_y, q_z;
	logic [COORD_WIDTH-2:0] q_radius, q_height;

	sbso_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.word_index(word_index),
		.word_value(word_value),
		.q_full(q_full),
		.back_busy(back_busy),
		.push(push),
		.vol(vol),
		.norm(norm)
	);

	sbso_queue #(.CW(COORD_WIDTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.in_x(feet_x),
		.in_y(feet_y),
		.in_z(feet_z),
		.in_radius(body_radius),
		.in_height(body_height),
		.pop(pop),
		.out_x(q_x),
		.out_y(q_y),
		.out_z(q_z),
		.out_radius(q_radius),
		.out_height(q_height),
		.nonempty(q_nonempty),
		.full(q_full)
	);

	sbso_back #(.CW(COORD_WIDTH), .F(RECIP_FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.vol(vol),
		.norm(norm),
		.q_nonempty(q_nonempty),
		.q_x(q_x),
		.q_y(q_y),
		.q_z(q_z),
		.q_radius(q_radius),
		.q_height(q_height),
		.pop(pop),
		.busy(back_busy),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.overlap(overlap),
		.reject_cause(reject_cause)
	);

endmodule

/* rtl/core/sbso_norm.sv */
module sbso_norm (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [sbso_pkg::WORD_W-1:0] nx,
	input  logic signed [sbso_pkg::WORD_W-1:0] ny,
	output logic [sbso_pkg::NORM_W-1:0] root,
	output sbso_pkg::nrm_stat_t stat
);
	import sbso_pkg::*;

	nrm_state_t state_q, state_d;
	logic signed [WORD_W-1:0] nx_q, ny_q;
	logic signed [2*WORD_W-1:0] sqx, sqy;
	logic [63:0] v_q, root_q, bit_q, v_n, root_n;
	logic [64:0] trial;
	logic ge;
	logic [4:0] cnt_q;

	assign sqx = (2*WORD_W)'(nx_q) * (2*WORD_W)'(nx_q);
	assign sqy = (2*WORD_W)'(ny_q) * (2*WORD_W)'(ny_q);

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign ge = {1'b0, v_q} >= trial;
	assign v_n = ge ? (v_q - trial[63:0]) : v_q;
	assign root_n = ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	assign root = root_n[NORM_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			NRM_IDLE: if (start) state_d = NRM_SQUARE;
			NRM_SQUARE: state_d = NRM_ROOT;
			NRM_ROOT: if (cnt_q == '0) state_d = NRM_IDLE;
			default: state_d = NRM_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = state_q != NRM_IDLE;
		stat.done = (state_q == NRM_ROOT) && (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NRM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			NRM_IDLE: begin
				if (start) begin
					nx_q <= nx;
					ny_q <= ny;
				end
			end
			NRM_SQUARE: begin
				v_q <= 64'(sqx) + 64'(sqy);
				root_q <= '0;
				bit_q <= 64'd1 << 62;
				cnt_q <= 5'd31;
			end
			NRM_ROOT: begin
				v_q <= v_n;
				root_q <= root_n;
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 5'd1;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule

/* rtl/core/sbso_front.sv */
module sbso_front (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic action,
	input  logic [4:0] word_index,
	input  logic signed [sbso_pkg::WORD_W-1:0] word_value,
	input  logic q_full,
	input  logic back_busy,
	output logic push,
	output sbso_pkg::vol_t vol,
	output sbso_pkg::norm_t norm
);
	import sbso_pkg::*;

	vol_t vol_q;
	norm_t norm_q;
	logic [SLABS-1:0] dirty_q, wslab;
	logic [1:0] sel_d, sel_q;
	logic start, pending, accept, wr_en;
	logic signed [WORD_W-1:0] nx, ny;
	logic [NORM_W-1:0] root;
	nrm_stat_t stat;

	sbso_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.nx(nx),
		.ny(ny),
		.root(root),
		.stat(stat)
	);

	assign pending = stat.busy || (|dirty_q);
	assign start = !stat.busy && (|dirty_q);

	always_comb begin
		item_stall = (action == ACT_TEST) ? (q_full || pending) : (back_busy || pending);
	end

	assign accept = item_valid && !item_stall;
	assign push = accept && (action == ACT_TEST);
	assign wr_en = accept && (action == ACT_LOAD) && (word_index < 5'(VOLUME_DEPTH));

	always_comb begin
		sel_d = '0;
		for (int k = SLABS - 1; k >= 0; k--) begin
			if (dirty_q[k]) sel_d = 2'(k);
		end
	end

	always_comb begin
		nx = vol_q[IDX_RECIP];
		ny = vol_q[IDX_RECIP + 1];
		for (int k = 0; k < SLABS; k++) begin
			if (sel_d == 2'(k)) begin
				nx = vol_q[IDX_RECIP + 3 * k];
				ny = vol_q[IDX_RECIP + 3 * k + 1];
			end
		end
	end

	always_comb begin
		case (word_index) inside
			[5'd9:5'd11]: wslab = 3'b001;
			[5'd12:5'd14]: wslab = 3'b010;
			[5'd15:5'd17]: wslab = 3'b100;
			default: wslab = 3'b000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOLUME_DEPTH; i++) vol_q[i] <= '0;
			for (int k = 0; k < SLABS; k++) norm_q[k] <= '0;
			dirty_q <= '0;
			sel_q <= '0;
		end else begin
			if (wr_en) begin
				vol_q[word_index] <= word_value;
				dirty_q <= dirty_q | wslab;
			end else if (start) begin
				dirty_q[sel_d] <= 1'b0;
				sel_q <= sel_d;
			end
			if (stat.done) norm_q[sel_q] <= root;
		end
	end

	assign vol = vol_q;
	assign norm = norm_q;

endmodule

/* rtl/core/sbso_queue.sv */
module sbso_queue #(
	parameter int CW = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic signed [CW-1:0] in_z,
	input  logic [CW-2:0] in_radius,
	input  logic [CW-2:0] in_height,
	input  logic pop,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output logic signed [CW-1:0] out_z,
	output logic [CW-2:0] out_radius,
	output logic [CW-2:0] out_height,
	output logic nonempty,
	output logic full
);
	import sbso_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic signed [CW-1:0] x_q[QUEUE_DEPTH], y_q[QUEUE_DEPTH], z_q[QUEUE_DEPTH];
	logic [CW-2:0] r_q[QUEUE_DEPTH], h_q[QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic do_pop;

	assign nonempty = cnt_q != '0;
	assign full = cnt_q == (AW + 1)'(QUEUE_DEPTH);
	assign do_pop = pop && nonempty;

	assign out_x = x_q[rd_q];
	assign out_y = y_q[rd_q];
	assign out_z = z_q[rd_q];
	assign out_radius = r_q[rd_q];
	assign out_height = h_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			case ({push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			x_q[wr_q] <= in_x;
			y_q[wr_q] <= in_y;
			z_q[wr_q] <= in_z;
			r_q[wr_q] <= in_radius;
			h_q[wr_q] <= in_height;
		end
	end

endmodule

/* rtl/core/sbso_div.sv */
module sbso_div #(
	parameter int NW = 61,
	parameter int DW = 56,
	parameter int F = 24
) (
	input  logic clk,
	input  logic en,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic signed [F+2:0] quo
);
	localparam int ST = F + 2;
	localparam int CMPW = (NW + 7 > DW) ? NW + 7 : DW;
	localparam logic [F+1:0] Q_SAT = {2'b10, {F{1'b0}}};

	logic [NW-1:0] nmag;
	logic [DW-1:0] dmag;
	logic [CMPW-1:0] nsh, dext;
	logic [DW-1:0] r_q[ST], d_q[ST];
	logic [F:0] q_q[ST];
	logic [ST-1:0] neg_q, sat_q;
	logic [F+1:0] qf;

	assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
	assign dmag = den[DW-1] ? DW'(-den) : DW'(den);
	assign nsh = CMPW'({nmag, 7'b0});
	assign dext = CMPW'(dmag);

	always_ff @(posedge clk) begin
		if (en) begin
			r_q[0] <= nsh[DW-1:0];
			d_q[0] <= dmag;
			q_q[0] <= '0;
			neg_q[0] <= num[NW-1] ^ den[DW-1];
			sat_q[0] <= nsh >= dext;
		end
	end

	for (genvar i = 1; i < ST; i++) begin : g_stage
		logic [DW:0] r2;
		logic ge;
		assign r2 = {r_q[i-1], 1'b0};
		assign ge = r2 >= {1'b0, d_q[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[i] <= ge ? DW'(r2 - {1'b0, d_q[i-1]}) : DW'(r2);
				q_q[i] <= {q_q[i-1][F-1:0], ge};
				d_q[i] <= d_q[i-1];
				neg_q[i] <= neg_q[i-1];
				sat_q[i] <= sat_q[i-1];
			end
		end
	end

	assign qf = sat_q[ST-1] ? Q_SAT : {1'b0, q_q[ST-1]};
	assign quo = neg_q[ST-1] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});

endmodule

/* rtl/core/sbso_back.sv */
module sbso_back #(
	parameter int CW = 24,
	parameter int F = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  sbso_pkg::vol_t vol,
	input  sbso_pkg::norm_t norm,
	input  logic q_nonempty,
	input  logic signed [CW-1:0] q_x,
	input  logic signed [CW-1:0] q_y,
	input  logic signed [CW-1:0] q_z,
	input  logic [CW-2:0] q_radius,
	input  logic [CW-2:0] q_height,
	output logic pop,
	output logic busy,
	output logic result_valid,
	input  logic result_stall,
	output logic overlap,
	output logic [1:0] reject_cause
);
	import sbso_pkg::*;

	localparam int RW = CW - 1;
	localparam int LW = WORD_W + 1;
	localparam int MW = LW + WORD_W;
	localparam int PW = MW - 8 + 2;
	localparam int PADPW = RW + NORM_W;
	localparam int PADW = PADPW - 8;
	localparam int DW = RW + WORD_W + 1;
	localparam int NW = PW + 2;
	localparam int TW = F + 3;
	localparam int L = F + 2;
	localparam int BW = WORD_W + 2;
	localparam logic [DW-1:0] PAR_LIMIT =
		DW'(((64'd1 << (8 + F)) + 64'd99999999) / 64'd100000000);
	localparam logic signed [NW-1:0] ONE_N = NW'(64'd1 << F);
	localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << F);

	logic adv, out_valid_q;
	logic v_s1, v_s2, v_s3;
	logic [L-1:0] vd_q;
	slab_flags_t fl_q[L];
	slab_flags_t fl_d;
	cause_t cause_d, cause_q;

	logic signed [CW-1:0] feet[SLABS];
	logic signed [LW-1:0] loc_d[SLABS], loc_s1[SLABS];
	logic signed [DW-1:0] d_d[SLABS], d_s1[SLABS], d_s2[SLABS], d_s3[SLABS];
	logic [PADPW-1:0] padp_d[SLABS], padp_s1[SLABS];
	logic [PADW-1:0] pad_s2[SLABS], pad_s3[SLABS];
	logic signed [MW-1:0] prod_s2[SLABS][SLABS];
	logic signed [PW-1:0] p_s3[SLABS];
	logic bnd_d, bnd_s1, bnd_s2, bnd_s3;
	logic signed [NW-1:0] num_a[SLABS], num_b[SLABS];
	logic signed [TW-1:0] ta[SLABS], tb[SLABS];
	logic signed [BW-1:0] bfx, bfy, bfz, brad, bhgt;

	assign adv = !out_valid_q || !result_stall;
	assign pop = adv && q_nonempty;
	assign busy = q_nonempty || v_s1 || v_s2 || v_s3 || (|vd_q);

	assign feet[0] = q_x;
	assign feet[1] = q_y;
	assign feet[2] = q_z;

	assign bfx = BW'(q_x);
	assign bfy = BW'(q_y);
	assign bfz = BW'(q_z);
	assign brad = BW'($signed({1'b0, q_radius}));
	assign bhgt = BW'($signed({1'b0, q_height}));

	always_comb begin
		bnd_d = (bfx + brad < BW'(vol[IDX_MIN])) || (bfx - brad > BW'(vol[IDX_MAX])) ||
			(bfy + brad < BW'(vol[IDX_MIN + 1])) || (bfy - brad > BW'(vol[IDX_MAX + 1])) ||
			(bfz + bhgt < BW'(vol[IDX_MIN + 2])) || (bfz > BW'(vol[IDX_MAX + 2]));
		for (int c = 0; c < SLABS; c++) begin
			loc_d[c] = LW'(feet[c]) - LW'(vol[IDX_ORIGIN + c]);
		end
		for (int k = 0; k < SLABS; k++) begin
			d_d[k] = DW'($signed({1'b0, q_height})) * DW'(vol[IDX_RECIP + 3 * k + 2]);
			padp_d[k] = PADPW'(q_radius) * PADPW'(norm[k]);
		end
	end

	always_comb begin
		fl_d.bounds = bnd_s3;
		for (int k = 0; k < SLABS; k++) begin
			num_a[k] = -NW'($signed({1'b0, pad_s3[k]})) - NW'(p_s3[k]);
			num_b[k] = ONE_N + NW'($signed({1'b0, pad_s3[k]})) - NW'(p_s3[k]);
			fl_d.par[k] = (d_s3[k][DW-1] ? DW'(-d_s3[k]) : DW'(d_s3[k])) < PAR_LIMIT;
			fl_d.par_rej[k] = (NW'(p_s3[k]) < -NW'($signed({1'b0, pad_s3[k]}))) ||
				(NW'(p_s3[k]) > ONE_N + NW'($signed({1'b0, pad_s3[k]})));
		end
	end

	for (genvar k = 0; k < SLABS; k++) begin : g_slab
		sbso_div #(.NW(NW), .DW(DW), .F(F)) u_div_a (
			.clk(clk),
			.en(adv),
			.num(num_a[k]),
			.den(d_s3[k]),
			.quo(ta[k])
		);
		sbso_div #(.NW(NW), .DW(DW), .F(F)) u_div_b (
			.clk(clk),
			.en(adv),
			.num(num_b[k]),
			.den(d_s3[k]),
			.quo(tb[k])
		);
	end

	always_comb begin
		logic done;
		logic signed [TW-1:0] enter, leave, lo, hi;
		slab_flags_t fl;
		fl = fl_q[L-1];
		done = 1'b0;
		enter = '0;
		leave = ONE_T;
		lo = '0;
		hi = '0;
		cause_d = CAUSE_HIT;
		if (fl.bounds) begin
			cause_d = CAUSE_BOUNDS;
			done = 1'b1;
		end
		for (int k = 0; k < SLABS; k++) begin
			if (!done) begin
				if (fl.par[k]) begin
					if (fl.par_rej[k]) begin
						cause_d = CAUSE_PARALLEL;
						done = 1'b1;
					end
				end else begin
					lo = (ta[k] > tb[k]) ? tb[k] : ta[k];
					hi = (ta[k] > tb[k]) ? ta[k] : tb[k];
					if (lo > enter) enter = lo;
					if (hi < leave) leave = hi;
					if (enter > leave) begin
						cause_d = CAUSE_EMPTY;
						done = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vd_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vd_q <= {vd_q[L-2:0], v_s3};
			out_valid_q <= vd_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bnd_s1 <= bnd_d;
			bnd_s2 <= bnd_s1;
			bnd_s3 <= bnd_s2;
			for (int k = 0; k < SLABS; k++) begin
				loc_s1[k] <= loc_d[k];
				d_s1[k] <= d_d[k];
				d_s2[k] <= d_s1[k];
				d_s3[k] <= d_s2[k];
				padp_s1[k] <= padp_d[k];
				pad_s2[k] <= padp_s1[k][PADPW-1:8];
				pad_s3[k] <= pad_s2[k];
				for (int c = 0; c < SLABS; c++) begin
					prod_s2[k][c] <= MW'(loc_s1[c]) * MW'(vol[IDX_RECIP + 3 * k + c]);
				end
				p_s3[k] <= PW'(prod_s2[k][0] >>> 8) + PW'(prod_s2[k][1] >>> 8) +
					PW'(prod_s2[k][2] >>> 8);
			end
			fl_q[0] <= fl_d;
			for (int i = 1; i < L; i++) fl_q[i] <= fl_q[i-1];
			cause_q <= cause_d;
		end
	end

	assign result_valid = out_valid_q;
	assign overlap = cause_q == CAUSE_HIT;
	assign reject_cause = cause_q;

endmodule
